### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg
// shared constants for the peak and rms level meter and its arithmetic units
// ----------------------------------------------------------------------------
`default_nettype none

package prl_pkg;

    // channel layout of one frame
    localparam int MAX_CHANNELS  = 8;
    localparam int CH_IDX_BITS   = $clog2(MAX_CHANNELS);
    localparam int CHAN_CFG_BITS = 4;

    // published levels and accumulator
    localparam int LEVEL_BITS = 24;
    localparam int SUM_BITS   = 62;
    localparam int COUNT_BITS = 16;
    localparam int ROOT_W     = SUM_BITS / 2;

    // shared divider, two quotient bits per cycle
    localparam int DIV_W        = 64;
    localparam int DEN_W        = 16;
    localparam int DIV_STEPS    = DIV_W / 2;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PUBLISH_PERIOD = 2'd1;

    localparam logic [CHAN_CFG_BITS-1:0] CHAN_COUNT_RESET = 4'd2;
    localparam logic [COUNT_BITS-1:0]    PERIOD_RESET     = 16'd1024;

endpackage

`default_nettype wire

### rtl/prl_div.sv
// ----------------------------------------------------------------------------
// prl_div
// restoring unsigned divider, 64-bit dividend by 16-bit divisor,
// two quotient bits per cycle, done is registered and pulses in the cycle after the last step
// ----------------------------------------------------------------------------
`default_nettype none

module prl_div import prl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]        quo_reg, quo_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DEN_W:0]          step_a;
    logic [DEN_W:0]          step_b;

    // one restoring step: quotient bit on top, new remainder below
    function automatic logic [DEN_W:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic             in_bit,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0] part;
        logic [DEN_W:0] diff;
        part = {rem, in_bit};
        diff = part - {1'b0, den};
        if (part >= {1'b0, den})
        begin
            return {1'b1, diff[DEN_W-1:0]};
        end
        return {1'b0, part[DEN_W-1:0]};
    endfunction

    // two chained steps per cycle
    always_comb
    begin
        step_a = div_step(rem_reg, quo_reg[DIV_W-1], den_reg);
        step_b = div_step(step_a[DEN_W-1:0], quo_reg[DIV_W-2], den_reg);
    end

    // sequencing
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-3:0], step_a[DEN_W], step_b[DEN_W]};
            rem_next = step_b[DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/prl_isqrt.sv
// ----------------------------------------------------------------------------
// prl_isqrt
// digit-by-digit integer square root of a 62-bit value,
// one result bit per cycle, done is registered and pulses in the cycle after the last step
// ----------------------------------------------------------------------------
`default_nettype none

module prl_isqrt import prl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUM_BITS-1:0] value,
    output logic                done,
    output logic [ROOT_W-1:0]   root
);

    localparam logic [SUM_BITS-1:0] TOP_BIT = SUM_BITS'(1) << (SUM_BITS - 2);

    logic [SUM_BITS-1:0] x_reg, x_next;
    logic [SUM_BITS-1:0] res_reg, res_next;
    logic [SUM_BITS-1:0] bit_reg, bit_next;
    logic                done_reg, done_next;
    logic [SUM_BITS-1:0] trial;

    // trial subtract of res + bit, the walking bit doubles as step counter
    always_comb
    begin
        trial     = res_reg + bit_reg;
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next   = value;
            res_next = '0;
            bit_next = TOP_BIT;
        end
        else if (bit_reg != '0)
        begin
            if (x_reg >= trial)
            begin
                x_next   = x_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next  = bit_reg >> 2;
            done_next = bit_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            x_reg    <= x_next;
            res_reg  <= res_next;
            bit_reg  <= bit_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

`default_nettype wire

### rtl/peak_rms_level_meter.sv
// ----------------------------------------------------------------------------
// peak_rms_level_meter
// Meters peak and rms of multichannel audio, one frame per input item. Each
// frame walks its metered channels one per cycle through a magnitude, square
// and accumulate pipeline, then the shared 2-bit-per-cycle divider scales the
// frame's sum of squares by the channel count. A frame that ends a
// publish period runs the divider again over the frame count and then the
// 1-bit-per-cycle square root unit. Input is not taken while a frame is
// being worked on. Every item gives one result item carrying the last
// published levels; the output register lets the next frame be accepted
// while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_rms_level_meter import prl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_0,
    input  logic signed [SAMPLE_BITS-1:0] sample_1,
    input  logic signed [SAMPLE_BITS-1:0] sample_2,
    input  logic signed [SAMPLE_BITS-1:0] sample_3,
    input  logic signed [SAMPLE_BITS-1:0] sample_4,
    input  logic signed [SAMPLE_BITS-1:0] sample_5,
    input  logic signed [SAMPLE_BITS-1:0] sample_6,
    input  logic signed [SAMPLE_BITS-1:0] sample_7,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [LEVEL_BITS-1:0]         peak_level,
    output logic [LEVEL_BITS-1:0]         rms_level,
    output logic                          published
);

    localparam int MAG_W  = SAMPLE_BITS;
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int SQ_RAW = 2 * SAMPLE_BITS - 1 + $clog2(MAX_CHANNELS);
    localparam int SQ_W   = (SQ_RAW > DIV_W) ? DIV_W : SQ_RAW;
    localparam int PK_W   = (MAG_W > LEVEL_BITS) ? MAG_W : LEVEL_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAN,
        S_DRAIN,
        S_DIVC,
        S_ACC,
        S_DIVN,
        S_SQRT,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;

    logic [CHAN_CFG_BITS-1:0] ch_count_reg, ch_count_next;
    logic [COUNT_BITS-1:0]    period_reg, period_next;

    logic [SAMPLE_BITS-1:0]   sample_in [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0]   smp_reg   [MAX_CHANNELS];

    logic [CH_IDX_BITS-1:0]   ch_reg, ch_next;
    logic [CH_IDX_BITS-1:0]   last_ch_reg, last_ch_next;
    logic [CHAN_CFG_BITS-1:0] chans_reg, chans_next;
    logic [CHAN_CFG_BITS-1:0] chans_eff;

    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     mag_vld_reg, mag_vld_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic                     prod_vld_reg, prod_vld_next;
    logic [SQ_W-1:0]          sq_reg, sq_next;
    logic [PK_W-1:0]          pk_reg, pk_next;

    logic [LEVEL_BITS-1:0]    peak_hold_reg, peak_hold_next;
    logic [SUM_BITS-1:0]      square_sum_reg, square_sum_next;
    logic [COUNT_BITS-1:0]    frame_count_reg, frame_count_next;
    logic [LEVEL_BITS-1:0]    held_peak_reg, held_peak_next;
    logic [LEVEL_BITS-1:0]    held_rms_reg, held_rms_next;
    logic                     pub_reg, pub_next;

    logic                     out_valid_reg, out_valid_next;
    logic [LEVEL_BITS-1:0]    peak_level_reg, peak_level_next;
    logic [LEVEL_BITS-1:0]    rms_level_reg, rms_level_next;
    logic                     published_reg, published_next;

    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [DEN_W-1:0]         div_divisor;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quo;
    logic                     sqrt_start;
    logic                     sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;
    logic                     publish_now;

    // magnitude of a two's complement sample, most negative maps to 2^(n-1)
    function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_BITS-1:0] raw);
        if (raw[SAMPLE_BITS-1])
        begin
            return (~raw) + MAG_W'(1);
        end
        return raw;
    endfunction

    assign sample_in[0] = sample_0;
    assign sample_in[1] = sample_1;
    assign sample_in[2] = sample_2;
    assign sample_in[3] = sample_3;
    assign sample_in[4] = sample_4;
    assign sample_in[5] = sample_5;
    assign sample_in[6] = sample_6;
    assign sample_in[7] = sample_7;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);

    // channel count clamped to 1..MAX_CHANNELS
    always_comb
    begin
        if (ch_count_reg == '0)
        begin
            chans_eff = CHAN_CFG_BITS'(1);
        end
        else if (ch_count_reg > CHAN_CFG_BITS'(MAX_CHANNELS))
        begin
            chans_eff = CHAN_CFG_BITS'(MAX_CHANNELS);
        end
        else
        begin
            chans_eff = ch_count_reg;
        end
    end

    // period reached, or the frame counter wrapped to zero
    assign publish_now = (frame_count_reg >= period_reg) || (frame_count_reg == '0);

    // divider operand select: per-frame scaling or the publish average
    always_comb
    begin
        if (state_reg == S_ACC)
        begin
            div_dividend = DIV_W'(square_sum_reg);
            div_divisor  = (frame_count_reg == '0) ? DEN_W'(1) : DEN_W'(frame_count_reg);
        end
        else
        begin
            div_dividend = DIV_W'(sq_reg);
            div_divisor  = DEN_W'(chans_reg);
        end
    end

    // frame sequencer
    always_comb
    begin
        state_next       = state_reg;
        ch_count_next    = ch_count_reg;
        period_next      = period_reg;
        ch_next          = ch_reg;
        last_ch_next     = last_ch_reg;
        chans_next       = chans_reg;
        mag_next         = mag_reg;
        mag_vld_next     = 1'b0;
        prod_next        = prod_reg;
        prod_vld_next    = 1'b0;
        sq_next          = sq_reg;
        pk_next          = pk_reg;
        peak_hold_next   = peak_hold_reg;
        square_sum_next  = square_sum_reg;
        frame_count_next = frame_count_reg;
        held_peak_next   = held_peak_reg;
        held_rms_next    = held_rms_reg;
        pub_next         = pub_reg;
        out_valid_next   = out_valid_reg;
        peak_level_next  = peak_level_reg;
        rms_level_next   = rms_level_reg;
        published_next   = published_reg;
        div_start        = 1'b0;
        sqrt_start       = 1'b0;

        // square and peak stage
        if (mag_vld_reg)
        begin
            prod_next     = PROD_W'(mag_reg) * PROD_W'(mag_reg);
            prod_vld_next = 1'b1;
            if (PK_W'(mag_reg) > pk_reg)
            begin
                pk_next = PK_W'(mag_reg);
            end
        end

        // accumulate stage
        if (prod_vld_reg)
        begin
            sq_next = sq_reg + SQ_W'(prod_reg);
        end

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CHANNEL_COUNT:  ch_count_next = cfg_data[CHAN_CFG_BITS-1:0];
                CFG_PUBLISH_PERIOD: period_next   = cfg_data[COUNT_BITS-1:0];
                default:            ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next      = '0;
                    chans_next   = chans_eff;
                    last_ch_next = CH_IDX_BITS'(chans_eff - 1'b1);
                    sq_next      = '0;
                    pk_next      = PK_W'(peak_hold_reg);
                    state_next   = S_CHAN;
                end
            end
            S_CHAN:
            begin
                mag_next     = magnitude(smp_reg[ch_reg]);
                mag_vld_next = 1'b1;
                if (ch_reg == last_ch_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    ch_next = ch_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!mag_vld_reg && !prod_vld_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVC;
                end
            end
            S_DIVC:
            begin
                if (div_done)
                begin
                    square_sum_next  = square_sum_reg + SUM_BITS'(div_quo);
                    frame_count_next = frame_count_reg + 1'b1;
                    peak_hold_next   = LEVEL_BITS'(pk_reg);
                    state_next       = S_ACC;
                end
            end
            S_ACC:
            begin
                if (publish_now)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVN;
                end
                else
                begin
                    pub_next   = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DIVN:
            begin
                if (div_done)
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_done)
                begin
                    held_peak_next   = peak_hold_reg;
                    held_rms_next    = LEVEL_BITS'(sqrt_root);
                    peak_hold_next   = '0;
                    square_sum_next  = '0;
                    frame_count_next = '0;
                    pub_next         = 1'b1;
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    peak_level_next = held_peak_reg;
                    rms_level_next  = held_rms_reg;
                    published_next  = pub_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ch_count_reg    <= CHAN_COUNT_RESET;
            period_reg      <= PERIOD_RESET;
            ch_reg          <= '0;
            last_ch_reg     <= '0;
            chans_reg       <= '0;
            mag_reg         <= '0;
            mag_vld_reg     <= 1'b0;
            prod_reg        <= '0;
            prod_vld_reg    <= 1'b0;
            sq_reg          <= '0;
            pk_reg          <= '0;
            peak_hold_reg   <= '0;
            square_sum_reg  <= '0;
            frame_count_reg <= '0;
            held_peak_reg   <= '0;
            held_rms_reg    <= '0;
            pub_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            peak_level_reg  <= '0;
            rms_level_reg   <= '0;
            published_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ch_count_reg    <= ch_count_next;
            period_reg      <= period_next;
            ch_reg          <= ch_next;
            last_ch_reg     <= last_ch_next;
            chans_reg       <= chans_next;
            mag_reg         <= mag_next;
            mag_vld_reg     <= mag_vld_next;
            prod_reg        <= prod_next;
            prod_vld_reg    <= prod_vld_next;
            sq_reg          <= sq_next;
            pk_reg          <= pk_next;
            peak_hold_reg   <= peak_hold_next;
            square_sum_reg  <= square_sum_next;
            frame_count_reg <= frame_count_next;
            held_peak_reg   <= held_peak_next;
            held_rms_reg    <= held_rms_next;
            pub_reg         <= pub_next;
            out_valid_reg   <= out_valid_next;
            peak_level_reg  <= peak_level_next;
            rms_level_reg   <= rms_level_next;
            published_reg   <= published_next;
        end
    end

    // frame capture on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                smp_reg[i] <= sample_in[i];
            end
        end
    end

    // shared divider
    prl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // square root unit
    prl_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (SUM_BITS'(div_quo)),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign out_valid  = out_valid_reg;
    assign peak_level = peak_level_reg;
    assign rms_level  = rms_level_reg;
    assign published  = published_reg;

    // checks
    `include "assert_macros.svh"

    `ASSERT_IMP(a_div_done_expected, div_done, state_reg == S_DIVC || state_reg == S_DIVN)
    `ASSERT_IMP(a_sqrt_done_expected, sqrt_done, state_reg == S_SQRT)
    `ASSERT_IMP(a_idle_pipe_empty, state_reg == S_IDLE, !mag_vld_reg && !prod_vld_reg)
    `ASSERT_NEXT(a_publish_clears, state_reg == S_SQRT && sqrt_done, frame_count_reg == '0 && square_sum_reg == '0 && pub_reg)

endmodule

`default_nettype wire

### sim/peak_rms_level_meter_tb.sv
// ----------------------------------------------------------------------------
// peak_rms_level_meter_tb
// Self-checking bench for the peak and rms level meter. A short table of
// directed frames and register writes covers the sample extremes, the channel
// count clamps, a zero publish period and a period lowered under the running
// count. Random phases with fresh settings follow. Every accepted frame runs
// through a local level predictor, and every result item is compared field by
// field with the oldest expected entry, table value or prediction. Both sides
// idle at random; one long result-side hold-off makes the input back up.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_rms_level_meter_tb import prl_pkg::*;;

    localparam int     SAMPLE_W      = 24;
    localparam int     RANDOM_FRAMES = 430;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     TAIL_CYCLES   = 200;
    localparam int     LONG_HOLD     = 600;
    localparam int     HOLD_AT       = 200;
    localparam int     QUIET_FROM    = 320;
    localparam int     QUIET_TO      = 360;
    localparam longint TIMEOUT       = 5_000_000;

    // register slots the block does not implement
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [SAMPLE_W-1:0] FULL_POS = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] FULL_NEG = 24'h800000;

    typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] frame_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] peak;
        logic [LEVEL_BITS-1:0] rms;
        logic                  pub;
    } levels_t;

    typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
        frame_t                    fr;
        logic                      fixed_want;
        levels_t                   want;
    } dir_row_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    frame_t                    frame_q   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [LEVEL_BITS-1:0]     peak_level;
    logic [LEVEL_BITS-1:0]     rms_level;
    logic                      published;

    // predictor copy of the registers and the metering state
    logic [CHAN_CFG_BITS-1:0] chan_cfg    = CHAN_COUNT_RESET;
    logic [COUNT_BITS-1:0]    period_cfg  = PERIOD_RESET;
    logic [LEVEL_BITS-1:0]    run_peak    = '0;
    logic [SUM_BITS-1:0]      run_squares = '0;
    logic [COUNT_BITS-1:0]    run_frames  = '0;
    logic [LEVEL_BITS-1:0]    shown_peak  = '0;
    logic [LEVEL_BITS-1:0]    shown_rms   = '0;

    levels_t pending_levels[$];
    int      errors       = 0;
    int      results_seen = 0;
    bit      sender_burst = 1'b0;

    peak_rms_level_meter #(
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_0   (frame_q[0]),
        .sample_1   (frame_q[1]),
        .sample_2   (frame_q[2]),
        .sample_3   (frame_q[3]),
        .sample_4   (frame_q[4]),
        .sample_5   (frame_q[5]),
        .sample_6   (frame_q[6]),
        .sample_7   (frame_q[7]),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .peak_level (peak_level),
        .rms_level  (rms_level),
        .published  (published)
    );

    always #5 clk = ~clk;

    // level predictor: meters one frame and returns the levels it reports
    function automatic levels_t meter_frame(input frame_t fr);
        int          c;
        logic [63:0] chans;
        logic [63:0] mag;
        logic [63:0] frame_sq;
        logic [63:0] peak_v;
        logic [63:0] mean;
        logic [63:0] rem;
        logic [63:0] root_v;
        logic [63:0] bit_v;
        levels_t     r;
        // out of range channel counts clamp to 1 and MAX_CHANNELS
        if (chan_cfg == 0)
            chans = 64'd1;
        else if (chan_cfg > MAX_CHANNELS)
            chans = 64'(MAX_CHANNELS);
        else
            chans = 64'(chan_cfg);
        peak_v   = 64'(run_peak);
        frame_sq = '0;
        for (c = 0; c < int'(chans); c++)
        begin
            mag = fr[c][SAMPLE_W-1] ? 64'(-64'($signed(fr[c]))) : 64'(fr[c]);
            if (mag > peak_v)
                peak_v = mag;
            frame_sq += mag * mag;
        end
        run_peak    = peak_v[LEVEL_BITS-1:0];
        run_squares = SUM_BITS'(64'(run_squares) + frame_sq / chans);
        run_frames  = run_frames + 1'b1;
        r.pub       = 1'b0;
        // end of period, a zero period or a wrapped count publishes too
        if (run_frames >= period_cfg || run_frames == 0)
        begin
            mean   = 64'(run_squares) / ((run_frames == 0) ? 64'd1 : 64'(run_frames));
            rem    = mean;
            root_v = '0;
            bit_v  = 64'd1 << 62;
            while (bit_v > rem)
                bit_v >>= 2;
            while (bit_v != 0)
            begin
                if (rem >= root_v + bit_v)
                begin
                    rem    = rem - (root_v + bit_v);
                    root_v = (root_v >> 1) + bit_v;
                end
                else
                begin
                    root_v >>= 1;
                end
                bit_v >>= 2;
            end
            shown_peak  = run_peak;
            shown_rms   = root_v[LEVEL_BITS-1:0];
            run_peak    = '0;
            run_squares = '0;
            run_frames  = '0;
            r.pub       = 1'b1;
        end
        r.peak = shown_peak;
        r.rms  = shown_rms;
        return r;
    endfunction

    function automatic dir_row_t wr_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] data);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic dir_row_t frame_row(input frame_t fr, input logic fixed_want,
                                           input logic [LEVEL_BITS-1:0] pk,
                                           input logic [LEVEL_BITS-1:0] rm,
                                           input logic pub);
        dir_row_t r;
        r            = '0;
        r.kind       = ROW_FRAME;
        r.fr         = fr;
        r.fixed_want = fixed_want;
        r.want       = '{peak: pk, rms: rm, pub: pub};
        return r;
    endfunction

    // drop input valid and wait until every result item is back
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write, block idle
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_CHANNEL_COUNT)
            chan_cfg = data[CHAN_CFG_BITS-1:0];
        else if (idx == CFG_PUBLISH_PERIOD)
            period_cfg = data;
        @(posedge clk);
    endtask

    // offer one frame item after a random gap, predict at acceptance
    task automatic send_frame(input frame_t fr, input logic fixed_want,
                              input levels_t want);
        int      pick;
        int      gap;
        levels_t predicted;
        pick = $urandom_range(0, 99);
        if (sender_burst || pick < 55)
            gap = 0;
        else if (pick < 88)
            gap = $urandom_range(1, 3);
        else if (pick < 97)
            gap = $urandom_range(4, 15);
        else
            gap = $urandom_range(30, 120);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        frame_q  <= fr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = meter_frame(fr);
        pending_levels.push_back(fixed_want ? want : predicted);
    endtask

    // result side: check accepted items, then pick the next stall
    always @(posedge clk)
    begin : result_side
        int      pick;
        int      stall_left;
        bit      hold_done;
        levels_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_levels.size() == 0)
                begin
                    $error("result item with nothing expected: peak_level %0d rms_level %0d",
                           peak_level, rms_level);
                    errors++;
                end
                else
                begin
                    want = pending_levels.pop_front();
                    if (peak_level !== want.peak)
                    begin
                        $error("peak_level: expected %0d, got %0d", want.peak, peak_level);
                        errors++;
                    end
                    if (rms_level !== want.rms)
                    begin
                        $error("rms_level: expected %0d, got %0d", want.rms, rms_level);
                        errors++;
                    end
                    if (published !== want.pub)
                    begin
                        $error("published: expected %0d, got %0d", want.pub, published);
                        errors++;
                    end
                end
                results_seen++;
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!hold_done && results_seen >= HOLD_AT)
            begin
                // long hold-off so the block backs up into its input
                hold_done  = 1'b1;
                out_stall <= 1'b1;
                stall_left = LONG_HOLD - 1;
            end
            else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    out_stall <= 1'b0;
                end
                else
                begin
                    out_stall <= 1'b1;
                    if (pick < 90)
                        stall_left = $urandom_range(0, 2);
                    else if (pick < 98)
                        stall_left = $urandom_range(3, 12);
                    else
                        stall_left = $urandom_range(20, 50);
                end
            end
        end
    end

    // stimulus: directed table, then random phases
    initial
    begin : stimulus
        dir_row_t                 plan[$];
        frame_t                   fr;
        int                       pick;
        int                       run_len;
        int                       rand_sent;
        int                       c;
        logic [CHAN_CFG_BITS-1:0] cc;
        logic [COUNT_BITS-1:0]    per;

        // reset values, only unmetered channels carry signal
        plan.push_back(frame_row({{6{FULL_POS}}, 24'h0, 24'h0}, 1'b1, 24'd0, 24'd0, 1'b0));
        // one channel, publish every frame
        plan.push_back(wr_row(CFG_CHANNEL_COUNT, 16'd1));
        plan.push_back(wr_row(CFG_PUBLISH_PERIOD, 16'd1));
        plan.push_back(frame_row({{7{FULL_NEG}}, FULL_POS}, 1'b0, '0, '0, 1'b0));
        // most negative sample, its magnitude still fits
        plan.push_back(frame_row({{7{FULL_POS}}, FULL_NEG}, 1'b1, 24'h800000, 24'h800000, 1'b1));
        plan.push_back(frame_row({{7{FULL_NEG}}, FULL_POS}, 1'b1, 24'h7FFFFF, 24'h7FFFFF, 1'b1));
        plan.push_back(frame_row({{7{FULL_NEG}}, 24'h0}, 1'b1, 24'd0, 24'd0, 1'b1));
        // channel count zero acts as one
        plan.push_back(wr_row(CFG_CHANNEL_COUNT, 16'd0));
        plan.push_back(frame_row({{7{FULL_POS}}, 24'hFFFFFF}, 1'b1, 24'd1, 24'd1, 1'b1));
        // channel count above the maximum clamps to all channels
        plan.push_back(wr_row(CFG_CHANNEL_COUNT, 16'd15));
        plan.push_back(frame_row({8{FULL_NEG}}, 1'b1, 24'h800000, 24'h800000, 1'b1));
        plan.push_back(wr_row(CFG_CHANNEL_COUNT, 16'hFFF9));
        plan.push_back(frame_row({24'hEDCBA9, 24'h123456, FULL_NEG, FULL_POS,
                                  24'hC00000, 24'h400000, 24'hFFFFFF, 24'h000001},
                                 1'b0, '0, '0, 1'b0));
        // zero period publishes on every frame
        plan.push_back(wr_row(CFG_PUBLISH_PERIOD, 16'd0));
        plan.push_back(frame_row({8{24'h000003}}, 1'b1, 24'd3, 24'd3, 1'b1));
        plan.push_back(frame_row({8{24'hFFFFFD}}, 1'b0, '0, '0, 1'b0));
        // four frame period, levels held in between
        plan.push_back(wr_row(CFG_CHANNEL_COUNT, 16'd8));
        plan.push_back(wr_row(CFG_PUBLISH_PERIOD, 16'd4));
        plan.push_back(frame_row({8{24'hAAAAAA}}, 1'b1, 24'd3, 24'd3, 1'b0));
        plan.push_back(frame_row({8{24'h555555}}, 1'b1, 24'd3, 24'd3, 1'b0));
        plan.push_back(frame_row({{4{FULL_POS}}, {4{FULL_NEG}}}, 1'b1, 24'd3, 24'd3, 1'b0));
        plan.push_back(frame_row({8{24'h000400}}, 1'b0, '0, '0, 1'b0));
        // longest period, then lowered under the running count
        plan.push_back(wr_row(CFG_CHANNEL_COUNT, 16'hA5A2));
        plan.push_back(wr_row(CFG_PUBLISH_PERIOD, 16'hFFFF));
        plan.push_back(frame_row({8{24'h3C3C3C}}, 1'b0, '0, '0, 1'b0));
        plan.push_back(frame_row({{6{24'h0}}, 24'hF0F0F0, 24'h0F0F0F}, 1'b0, '0, '0, 1'b0));
        plan.push_back(frame_row({{6{FULL_POS}}, 24'h000010, 24'hFFFFF0}, 1'b0, '0, '0, 1'b0));
        plan.push_back(wr_row(CFG_PUBLISH_PERIOD, 16'd2));
        plan.push_back(frame_row({8{24'h7F0000}}, 1'b0, '0, '0, 1'b0));
        // unused register slots leave the settings alone
        plan.push_back(wr_row(CFG_SPARE_2, 16'hFFFF));
        plan.push_back(wr_row(CFG_SPARE_3, 16'h5555));
        plan.push_back(frame_row({8{24'h012345}}, 1'b0, '0, '0, 1'b0));
        // equal magnitudes of both signs, strict peak test
        plan.push_back(wr_row(CFG_CHANNEL_COUNT, 16'd3));
        plan.push_back(wr_row(CFG_PUBLISH_PERIOD, 16'd3));
        plan.push_back(frame_row({{5{FULL_POS}}, 24'h000005, 24'hFFFFFB, 24'h000005},
                                 1'b0, '0, '0, 1'b0));
        plan.push_back(frame_row({{5{FULL_NEG}}, 24'hFFFFFB, 24'h000005, 24'hFFFFFB},
                                 1'b0, '0, '0, 1'b0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                settle_idle();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                send_frame(plan[i].fr, plan[i].fixed_want, plan[i].want);
            end
        end

        // random phases, each with its own settings
        rand_sent = 0;
        while (rand_sent < RANDOM_FRAMES)
        begin
            settle_idle();
            sender_burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                cc = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
            else
                cc = 4'($urandom_range(1, 8));
            pick = $urandom_range(0, 9);
            case (pick)
                0:       per = 16'd0;
                1:       per = 16'd1;
                8:       per = 16'($urandom_range(13, 64));
                9:       per = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom);
                default: per = 16'($urandom_range(2, 12));
            endcase
            pick = $urandom_range(0, 3);
            if (pick != 1)
                write_reg(CFG_CHANNEL_COUNT, {12'($urandom), cc});
            if (pick != 2)
                write_reg(CFG_PUBLISH_PERIOD, per);
            run_len = $urandom_range(20, 60);
            if (run_len > RANDOM_FRAMES - rand_sent)
                run_len = RANDOM_FRAMES - rand_sent;
            repeat (run_len)
            begin
                // mostly full random samples, some extremes and near-silence
                for (c = 0; c < MAX_CHANNELS; c++)
                begin
                    pick = $urandom_range(0, 9);
                    case (pick)
                        0:       fr[c] = FULL_POS;
                        1:       fr[c] = FULL_NEG;
                        2:       fr[c] = 24'(int'($urandom_range(0, 31)) - 16);
                        3:       fr[c] = '0;
                        default: fr[c] = 24'($urandom);
                    endcase
                end
                send_frame(fr, 1'b0, '0);
                rand_sent++;
            end
        end

        // drain and wait out the block
        settle_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("peak_rms_level_meter test passed");
        else
            $display("peak_rms_level_meter test failed");
        $finish;
    end

    // run limit
    initial
    begin
        #(TIMEOUT);
        $display("peak_rms_level_meter test failed");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl
rtl/prl_pkg.sv
rtl/prl_div.sv
rtl/prl_isqrt.sv
rtl/peak_rms_level_meter.sv
sim/peak_rms_level_meter_tb.sv
